// ===== sv/rtcm3_frame_deframer_top_defines.svh =====
// assertion macros for the deframer rtl, used by rtcm_core
`ifndef RTCM3_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define RTCM3_FRAME_DEFRAMER_TOP_DEFINES_SVH

// property checked on every clock edge outside reset
`define RTCM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define RTCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/rtcm_pkg.sv =====
// shared types, constants and the crc-24q byte update for the deframer
package rtcm_pkg;

    localparam logic [7:0]  PREAMBLE      = 8'hD3;
    localparam logic [24:0] CRC_POLY      = 25'h1864CFB;
    localparam logic [10:0] HEADER_BYTES  = 11'd3;
    localparam logic [10:0] FRAME_EXTRA   = 11'd6;
    localparam logic [10:0] FRAME_MAX_POS = 11'd1028;
    localparam int          TDATA_W       = 32;
    localparam int          TUSER_W       = 3;

    // result kind of one byte
    typedef enum logic [1:0] {
        ST_DISCARD = 2'd0,
        ST_TAKEN   = 2'd1,
        ST_CRC_OK  = 2'd2,
        ST_CRC_BAD = 2'd3
    } t_status;

    // byte held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } t_byte_item;

    // one result item
    typedef struct packed {
        t_status     status;
        logic [7:0]  echo_byte;
        logic [10:0] byte_index;
        logic [9:0]  frame_length;
        logic        is_payload;
    } t_result;

    // byte-wide crc-24q update, msb first, no final xor
    function automatic logic [23:0] crc24q_byte(input logic [23:0] crc, input logic [7:0] b);
        logic [24:0] c;
        c = {1'b0, crc ^ {b, 16'h0000}};
        for (int k = 0; k < 8; k++) begin
            c = {c[23:0], 1'b0};
            if (c[24]) begin
                c = c ^ CRC_POLY;
            end
        end
        return c[23:0];
    endfunction

endpackage

// ===== sv/rtcm3_frame_deframer_top.sv =====
// top level of the rtcm 3 frame deframer with crc-24q check
//
// input stream: one received byte per transfer on i_s_axis_tdata.
// output stream: exactly one result transfer per input byte, in order.
//   tdata carries the echoed byte, its position in the frame and the
//   decoded payload length; tuser carries the status and the payload flag.
// status: discarded while hunting, taken into frame, crc good or crc bad
//   on the last byte of a frame, after which the block hunts again.
// path: an accepted byte waits in the input register, its result is
//   computed from it and loaded into the result register, from which it
//   transfers (input register, then result register).
// throughput: one byte per cycle unless stalled; the crc-24q byte update
//   and position compare sit in the single stage between the two registers.
// stall: while the output is held, the result register keeps its transfer
//   and the input register takes at most one more byte before tready drops.
// reset: synchronous, active low; the block starts hunting for the
//   preamble with both registers empty.
module rtcm3_frame_deframer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,  // [7:0] rx_byte
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [7:0] echo_byte, [18:8] byte_index, [28:19] frame_length, [31:29] zero
    output logic [rtcm_pkg::TDATA_W-1:0]  o_m_axis_tdata,
    // [1:0] status, [2] is_payload
    output logic [rtcm_pkg::TUSER_W-1:0]  o_m_axis_tuser
);

    rtcm_pkg::t_byte_item item;
    rtcm_pkg::t_result    res;
    logic                 out_ready;
    logic                 fire;

    // byte moves from input register to result register
    assign fire = item.valid && out_ready;

    rtcm_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .i_byte     (i_s_axis_tdata),
        .i_dn_ready (out_ready),
        .o_ready    (o_s_axis_tready),
        .o_item     (item)
    );

    rtcm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item),
        .i_fire  (fire),
        .o_res   (res)
    );

    rtcm_out_reg u_out_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (fire),
        .i_res           (res),
        .i_m_axis_tready (i_m_axis_tready),
        .o_ready         (out_ready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

// ===== sv/rtcm_in_reg.sv =====
// input register stage of the deframer
module rtcm_in_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_byte,
    input  logic                  i_dn_ready,
    output logic                  o_ready,
    output rtcm_pkg::t_byte_item  o_item
);

    logic       r_valid;
    logic [7:0] r_byte;

    // space when empty or when the held byte moves on this cycle
    assign o_ready = !r_valid || i_dn_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // byte payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

    assign o_item.valid   = r_valid;
    assign o_item.rx_byte = r_byte;

endmodule

// ===== sv/rtcm_core.sv =====
// frame state, length decode and crc-24q check for one byte per cycle unless stalled
`include "rtcm3_frame_deframer_top_defines.svh"

module rtcm_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rtcm_pkg::t_byte_item  i_item,
    input  logic                  i_fire,
    output rtcm_pkg::t_result     o_res
);

    logic        r_in_frame, n_in_frame;
    logic [10:0] r_pos, n_pos;
    logic [9:0]  r_len, n_len;
    logic [23:0] r_crc, n_crc;
    logic [15:0] r_crc_hi, n_crc_hi;

    logic [7:0]  b;
    logic [10:0] len_ext;
    logic        frame_done;

    assign b       = i_item.rx_byte;
    assign len_ext = {1'b0, r_len};

    // next state and result for the byte in the input register
    always_comb begin
        n_in_frame         = r_in_frame;
        n_pos              = r_pos;
        n_len              = r_len;
        n_crc              = r_crc;
        n_crc_hi           = r_crc_hi;
        frame_done         = 1'b0;
        o_res.status       = rtcm_pkg::ST_TAKEN;
        o_res.echo_byte    = b;
        o_res.byte_index   = '0;
        o_res.frame_length = '0;
        o_res.is_payload   = 1'b0;
        if (!r_in_frame) begin
            if (b != rtcm_pkg::PREAMBLE) begin
                o_res.status = rtcm_pkg::ST_DISCARD;
            end else begin
                n_in_frame = 1'b1;
                n_len      = '0;
                n_crc_hi   = '0;
                n_crc      = rtcm_pkg::crc24q_byte(24'h000000, b);
                n_pos      = 11'd1;
            end
        end else begin
            o_res.byte_index = r_pos;
            priority if (r_pos == 11'd1) begin
                n_len = {b[1:0], 8'h00};
                n_crc = rtcm_pkg::crc24q_byte(r_crc, b);
            end else if (r_pos == 11'd2) begin
                n_len = {r_len[9:8], b};
                n_crc = rtcm_pkg::crc24q_byte(r_crc, b);
            end else if (r_pos < len_ext + rtcm_pkg::HEADER_BYTES) begin
                o_res.is_payload = 1'b1;
                n_crc            = rtcm_pkg::crc24q_byte(r_crc, b);
            end else if (r_pos < len_ext + rtcm_pkg::FRAME_EXTRA - 11'd1) begin
                n_crc_hi = {r_crc_hi[7:0], b};
            end else begin
                // last crc byte closes the frame
                o_res.status = ({r_crc_hi, b} == r_crc) ? rtcm_pkg::ST_CRC_OK
                                                        : rtcm_pkg::ST_CRC_BAD;
                frame_done   = 1'b1;
            end
            if (r_pos >= 11'd2) begin
                o_res.frame_length = n_len;
            end
            if (frame_done) begin
                n_in_frame = 1'b0;
                n_pos      = '0;
            end else begin
                n_pos = r_pos + 11'd1;
            end
        end
    end

    // frame state, updated when a byte moves to the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= '0;
            r_len      <= '0;
            r_crc      <= '0;
            r_crc_hi   <= '0;
        end else if (i_fire) begin
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
            r_len      <= n_len;
            r_crc      <= n_crc;
            r_crc_hi   <= n_crc_hi;
        end
    end

    // checks on the frame state
    `RTCM_ASSERT(a_pos_range, r_pos <= rtcm_pkg::FRAME_MAX_POS, "frame position out of range")
    `RTCM_ASSERT(a_hunt_pos_zero, r_in_frame || (r_pos == 11'd0), "position not zero while hunting")
    `RTCM_ASSERT(a_frame_pos_nonzero, !r_in_frame || (r_pos != 11'd0), "position zero inside frame")
    `RTCM_ASSERT_NEXT(a_end_hunts, i_fire && ((o_res.status == rtcm_pkg::ST_CRC_OK) || (o_res.status == rtcm_pkg::ST_CRC_BAD)), !r_in_frame, "still in frame after frame end")

endmodule

// ===== sv/rtcm_out_reg.sv =====
// result register driving the master stream
module rtcm_out_reg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  rtcm_pkg::t_result                 i_res,
    input  logic                              i_m_axis_tready,
    output logic                              o_ready,
    output logic                              o_m_axis_tvalid,
    output logic [rtcm_pkg::TDATA_W-1:0]      o_m_axis_tdata,
    output logic [rtcm_pkg::TUSER_W-1:0]      o_m_axis_tuser
);

    logic              r_valid;
    rtcm_pkg::t_result r_res;

    // space when empty or when the held result is taken this cycle
    assign o_ready = !r_valid || i_m_axis_tready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    // pack result fields onto the stream
    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {3'b000, r_res.frame_length, r_res.byte_index, r_res.echo_byte};
    assign o_m_axis_tuser  = {r_res.is_payload, r_res.status};

endmodule
